/* sv/indexed_insert_erase_list_core_macros.svh */
// Assertion helpers shared by the RTL; assertions compile out when SYNTH is defined.
`ifndef INDEXED_INSERT_ERASE_LIST_CORE_MACROS_SVH
`define INDEXED_INSERT_ERASE_LIST_CORE_MACROS_SVH

`ifndef SYNTH
`define IIEL_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define IIEL_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define IIEL_ASSERT_IMP(label, ante, cons)
`define IIEL_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* sv/iiel_pkg.sv */
package iiel_pkg;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_ERASE  = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [5:0]         position;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] read_data;
      logic [1:0]         status;
      logic [6:0]         count;
      logic               is_empty;
   } rsp_payload_type;

   // broadcast to every cell; cells compare their own index with the target
   typedef struct packed {
      logic write;       // load the new value at the target
      logic shift_up;    // cells above the target take the lower neighbor
      logic shift_down;  // cells at or above the target take the upper neighbor
   } cell_cmd_type;

endpackage

/* sv/iiel_cell.sv */
module iiel_cell
   import iiel_pkg::*;
#(
   parameter int IDX_W = 6,
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  cell_cmd_type       cmd,
   input  logic [IDX_W-1:0]   target,
   input  logic signed [31:0] lower_q,
   input  logic signed [31:0] upper_q,
   input  logic signed [31:0] wr_value,
   output logic signed [31:0] entry_q
);

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;
   logic               is_above;
   logic               is_at;

   assign is_above = IDX_W'(INDEX) > target;
   assign is_at    = IDX_W'(INDEX) == target;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.write && is_at) begin
         entry_in = wr_value;
      end else if (cmd.shift_up && is_above) begin
         entry_in = lower_q;
      end else if (cmd.shift_down && (is_above || is_at)) begin
         entry_in = upper_q;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

/* sv/indexed_insert_erase_list_core.sv */
// Ordered list held in a row of CAPACITY register cells; insert and erase shift the cells from the target up at once.
// Response: registered; response valid rises in the cycle after the request transfer.
// Throughput: one operation per cycle unless a held response stalls req_ready; cells load neighbors in parallel.
// Reset: synchronous, active high; clears the entry count and response valid, list reads empty.
// Cell contents are not reset; only entries below the count are ever read.
module indexed_insert_erase_list_core
   import iiel_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

`include "indexed_insert_erase_list_core_macros.svh"

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (FILL_W > 6) ? FILL_W : 6;

   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_payload_type    rsp_payload_ff;
   rsp_payload_type    rsp_payload_in;

   logic               req_fire;
   logic               full;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   fill_ext;
   logic [1:0]         status;
   logic signed [31:0] rd_data;
   logic [IDX_W-1:0]   rd_idx;
   logic [IDX_W-1:0]   target;
   cell_cmd_type       cmd;

   logic signed [31:0] entry_q [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = fill_ff == FILL_W'(CAPACITY);
   assign pos_ext   = CMP_W'(req_payload.position);
   assign fill_ext  = CMP_W'(fill_ff);
   assign rd_idx    = IDX_W'(req_payload.position);

   always_comb begin
      status  = ST_OK;
      rd_data = '0;
      cmd     = '0;
      target  = IDX_W'(req_payload.position);
      fill_in = fill_ff;
      unique case (req_payload.operation)
         OP_APPEND: begin
            target = IDX_W'(fill_ff);
            if (full) begin
               status = ST_FULL;
            end else begin
               cmd.write = req_fire;
               if (req_fire) fill_in = fill_ff + 1'b1;
            end
         end
         OP_INSERT: begin
            if (pos_ext > fill_ext) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               cmd.write    = req_fire;
               cmd.shift_up = req_fire;
               if (req_fire) fill_in = fill_ff + 1'b1;
            end
         end
         OP_ERASE: begin
            if (pos_ext >= fill_ext) begin
               status = ST_RANGE;
            end else begin
               cmd.shift_down = req_fire;
               if (req_fire) fill_in = fill_ff - 1'b1;
            end
         end
         OP_READ: begin
            if (pos_ext >= fill_ext) begin
               status = ST_RANGE;
            end else begin
               rd_data = entry_q[rd_idx];
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] lower_q;
      logic signed [31:0] upper_q;
      if (i == 0) begin : g_first
         assign lower_q = '0;
      end else begin : g_mid_lo
         assign lower_q = entry_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign upper_q = '0;
      end else begin : g_mid_hi
         assign upper_q = entry_q[i+1];
      end
      iiel_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .target   (target),
         .lower_q  (lower_q),
         .upper_q  (upper_q),
         .wr_value (req_payload.value),
         .entry_q  (entry_q[i])
      );
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (req_fire) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.read_data = rd_data;
         rsp_payload_in.status    = status;
         rsp_payload_in.count     = 7'(fill_in);
         rsp_payload_in.is_empty  = fill_in == '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `IIEL_ASSERT_IMP(a_fill_bound, 1'b1, fill_ff <= FILL_W'(CAPACITY))
   `IIEL_ASSERT_NXT(a_append_grows, req_fire && req_payload.operation == OP_APPEND && !full,
      fill_ff == $past(fill_ff) + 1'b1)
   `IIEL_ASSERT_IMP(a_full_status, rsp_valid_ff && rsp_payload_ff.status == ST_FULL,
      fill_ff == FILL_W'(CAPACITY))
   `IIEL_ASSERT_IMP(a_empty_flag, rsp_valid_ff,
      rsp_payload_ff.is_empty == (fill_ff == '0))
   `IIEL_ASSERT_IMP(a_err_no_data, rsp_valid_ff && rsp_payload_ff.status != ST_OK,
      rsp_payload_ff.read_data == '0)

endmodule
